// ----- hdl/svag_pkg.sv -----
// Shared types, codes and field widths of the strided view address generator.
package svag_pkg;

  localparam int OPCODE_W    = 2;
  localparam int INDEX_W     = 16;
  localparam int NUM_INDEX   = 4;
  localparam int RANK_W      = 3;
  localparam int SIZES_W     = 64;
  localparam int STRIDE_W    = 32;
  localparam int NUM_STRIDES = 4;
  localparam int BASE_W      = 32;
  localparam int ADDR_W      = 32;
  localparam int POS_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam int MAX_DIMS_DEF  = 4;
  localparam int DIM_BITS_DEF  = 16;
  localparam int ADDR_BITS_DEF = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_RESTART = 2'd0,
    OP_EMIT    = 2'd1,
    OP_LOOKUP  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_DONE     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANK    = 3'd0,
    CFG_SIZES   = 3'd1,
    CFG_STRIDE0 = 3'd2,
    CFG_STRIDE1 = 3'd3,
    CFG_STRIDE2 = 3'd4,
    CFG_STRIDE3 = 3'd5,
    CFG_BASE    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             last;
    status_t          status;
    logic             skip;
  } meta_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [ADDR_W-1:0] addr;
    logic              last;
    status_t           status;
  } res_t;

endpackage

// ----- hdl/svag_odo_cell.sv -----
// One digit of the walk odometer: holds a dimension counter and ripples the carry.
module svag_odo_cell
  import svag_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                step,
  input  logic                active,
  input  logic [DIM_BITS-1:0] size,
  input  logic                carry_in,
  output logic                carry_out,
  output logic [DIM_BITS-1:0] count,
  output logic                size_zero
);

  logic [DIM_BITS:0]   inc;
  logic                wrap;
  logic [DIM_BITS-1:0] count_next;

  assign inc       = {1'b0, count} + (DIM_BITS+1)'(1);
  assign wrap      = inc >= {1'b0, size};
  assign carry_out = active ? (carry_in && wrap) : carry_in;
  assign size_zero = active && (size == '0);

  always_comb begin
    count_next = count;
    if (clear) begin
      count_next = '0;
    end else if (step && active && carry_in) begin
      count_next = wrap ? '0 : inc[DIM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ----- hdl/svag_acc_cell.sv -----
// One address stage: adds the previous dimension's product and multiplies its own.
module svag_acc_cell
  import svag_pkg::*;
#(
  parameter int CELL      = 0,
  parameter int MAX_DIMS  = MAX_DIMS_DEF,
  parameter int DIM_BITS  = DIM_BITS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic [STRIDE_W-1:0]                stride,
  input  logic                               in_valid,
  input  meta_t                              in_meta,
  input  logic [MAX_DIMS-1:0][DIM_BITS-1:0]  in_idx,
  input  logic [DIM_BITS+STRIDE_W-1:0]       in_prod,
  input  logic [ADDR_BITS-1:0]               in_acc,
  input  logic                               in_ovf,
  output logic                               out_valid,
  output meta_t                              out_meta,
  output logic [MAX_DIMS-1:0][DIM_BITS-1:0]  out_idx,
  output logic [DIM_BITS+STRIDE_W-1:0]       out_prod,
  output logic [ADDR_BITS-1:0]               out_acc,
  output logic                               out_ovf
);

  localparam int PW = DIM_BITS + STRIDE_W;
  localparam int SW = ((ADDR_BITS > PW) ? ADDR_BITS : PW) + 1;

  logic [DIM_BITS-1:0] mul_idx;
  logic [SW-1:0]       sum;

  if (CELL < MAX_DIMS) begin : g_mul
    assign mul_idx = in_idx[CELL];
  end else begin : g_nomul
    assign mul_idx = '0;
  end

  assign sum = SW'(in_acc) + SW'(in_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_meta <= in_meta;
      out_idx  <= in_idx;
      out_prod <= PW'(mul_idx) * PW'(stride);
      out_acc  <= sum[ADDR_BITS-1:0];
      out_ovf  <= in_ovf || (|sum[SW-1:ADDR_BITS]);
    end
  end

endmodule

// ----- hdl/strided_view_address_generator.sv -----
// Strided view address generator: walk and lookup requests in, element addresses out.
// A request is taken in every cycle while the skid register is empty; its result passes
// through the MAX_DIMS + 1 address stages (one multiply per dimension, one add per stage)
// and the output register. The walk odometer updates in the cycle a request is taken, so
// emit requests may follow each other back to back. A stall on the output is absorbed by
// a one-entry skid register, so s_axis_tready depends only on registered state.
module strided_view_address_generator
  import svag_pkg::*;
#(
  parameter int MAX_DIMS  = MAX_DIMS_DEF,
  parameter int DIM_BITS  = DIM_BITS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,  // index0, index1, index2, index3
  input  logic [OPCODE_W-1:0]   s_axis_tuser,  // opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [63:0]           m_axis_tdata,  // address, linear_position
  output logic                  m_axis_tlast,
  output logic [STATUS_W-1:0]   m_axis_tuser,  // status
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW = DIM_BITS + STRIDE_W;

  logic [RANK_W-1:0]   rank;
  logic [SIZES_W-1:0]  dim_sizes;
  logic [STRIDE_W-1:0] stride_dim [NUM_STRIDES];
  logic [BASE_W-1:0]   base_offset;

  logic [POS_W-1:0] walk_position;
  logic             walk_finished;

  logic accept;
  logic adv;
  op_t  op;

  logic [MAX_DIMS-1:0]               active;
  logic [MAX_DIMS-1:0][DIM_BITS-1:0] size;
  logic [MAX_DIMS-1:0][DIM_BITS-1:0] walk_count;
  logic [MAX_DIMS-1:0][DIM_BITS-1:0] lookup_idx;
  logic [MAX_DIMS-1:0][DIM_BITS-1:0] sel_idx;
  logic [MAX_DIMS-1:0][DIM_BITS-1:0] addr_idx;
  logic [MAX_DIMS-1:0]               size_zero;
  logic [MAX_DIMS-1:0]               idx_over;
  logic [MAX_DIMS:0]                 carry;
  logic                              empty;
  logic                              oob;
  logic                              clear;
  logic                              step;
  meta_t                             front_meta;

  logic [BASE_W+ADDR_BITS-1:0] base_ext;

  logic                              chain_valid [MAX_DIMS+2];
  meta_t                             chain_meta  [MAX_DIMS+2];
  logic [MAX_DIMS-1:0][DIM_BITS-1:0] chain_idx   [MAX_DIMS+1];
  logic [PW-1:0]                     chain_prod  [MAX_DIMS+1];
  logic [ADDR_BITS-1:0]              chain_acc   [MAX_DIMS+2];
  logic                              chain_ovf   [MAX_DIMS+2];
  logic [STRIDE_W-1:0]               cell_stride [MAX_DIMS+1];

  logic [ADDR_BITS+ADDR_W-1:0] acc_ext;
  res_t                        pipe_res;
  res_t                        out_res;
  res_t                        skid_res;
  logic                        skid_valid;

  assign adv           = !skid_valid;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = op_t'(s_axis_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      rank        <= '0;
      dim_sizes   <= '0;
      stride_dim  <= '{default: '0};
      base_offset <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RANK:    rank          <= cfg_data[RANK_W-1:0];
        CFG_SIZES:   dim_sizes     <= cfg_data[SIZES_W-1:0];
        CFG_STRIDE0: stride_dim[0] <= cfg_data[STRIDE_W-1:0];
        CFG_STRIDE1: stride_dim[1] <= cfg_data[STRIDE_W-1:0];
        CFG_STRIDE2: stride_dim[2] <= cfg_data[STRIDE_W-1:0];
        CFG_STRIDE3: stride_dim[3] <= cfg_data[STRIDE_W-1:0];
        CFG_BASE:    base_offset   <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_dim
    logic [SIZES_W-1:0]        size_shift;
    logic [DIM_BITS+INDEX_W-1:0] index_ext;

    assign active[i] = {1'b0, rank} > 4'(i);

    if (DIM_BITS * i < SIZES_W) begin : g_size
      assign size_shift = dim_sizes >> (DIM_BITS * i);
      assign size[i]    = size_shift[DIM_BITS-1:0];
    end else begin : g_nosize
      assign size_shift = '0;
      assign size[i]    = size_shift[DIM_BITS-1:0];
    end

    if (i < NUM_INDEX) begin : g_index
      assign index_ext = {{DIM_BITS{1'b0}}, s_axis_tdata[INDEX_W*i +: INDEX_W]};
    end else begin : g_noindex
      assign index_ext = '0;
    end
    assign lookup_idx[i] = index_ext[DIM_BITS-1:0];
    assign idx_over[i]   = active[i] && (lookup_idx[i] >= size[i]);
    assign addr_idx[i]   = active[i] ? sel_idx[i] : '0;

    svag_odo_cell #(
      .DIM_BITS (DIM_BITS)
    ) u_odo (
      .clk       (clk),
      .rst       (rst),
      .clear     (clear),
      .step      (step),
      .active    (active[i]),
      .size      (size[i]),
      .carry_in  (carry[i+1]),
      .carry_out (carry[i]),
      .count     (walk_count[i]),
      .size_zero (size_zero[i])
    );
  end

  assign carry[MAX_DIMS] = 1'b1;
  assign empty           = |size_zero;
  assign oob             = |idx_over;
  assign clear           = accept && (op == OP_RESTART);
  assign step            = accept && (op == OP_EMIT) && !walk_finished && !empty;

  always_comb begin
    front_meta = '{pos: '0, last: 1'b0, status: ST_OK, skip: 1'b1};
    sel_idx    = '0;
    unique case (op)
      OP_RESTART: begin
        front_meta.status = empty ? ST_DONE : ST_OK;
      end
      OP_EMIT: begin
        if (walk_finished || empty) begin
          front_meta.status = ST_DONE;
        end else begin
          front_meta.skip = 1'b0;
          front_meta.pos  = walk_position;
          front_meta.last = carry[0];
          sel_idx         = walk_count;
        end
      end
      OP_LOOKUP: begin
        if (oob) begin
          front_meta.status = ST_RANGE;
        end else begin
          front_meta.skip = 1'b0;
          sel_idx         = lookup_idx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_position <= '0;
      walk_finished <= 1'b0;
    end else if (accept) begin
      unique case (op)
        OP_RESTART: begin
          walk_position <= '0;
          walk_finished <= empty;
        end
        OP_EMIT: begin
          if (walk_finished || empty) begin
            walk_finished <= 1'b1;
          end else begin
            walk_position <= walk_position + POS_W'(1);
            if (carry[0]) begin
              walk_finished <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign base_ext       = {{ADDR_BITS{1'b0}}, base_offset};
  assign chain_valid[0] = accept;
  assign chain_meta[0]  = front_meta;
  assign chain_idx[0]   = addr_idx;
  assign chain_prod[0]  = '0;
  assign chain_acc[0]   = base_ext[ADDR_BITS-1:0];
  assign chain_ovf[0]   = |base_ext[BASE_W+ADDR_BITS-1:ADDR_BITS];

  for (genvar k = 0; k <= MAX_DIMS; k++) begin : g_cell
    if (k < MAX_DIMS && k < NUM_STRIDES) begin : g_stride
      assign cell_stride[k] = stride_dim[k];
    end else begin : g_nostride
      assign cell_stride[k] = '0;
    end

    if (k < MAX_DIMS) begin : g_mid
      svag_acc_cell #(
        .CELL      (k),
        .MAX_DIMS  (MAX_DIMS),
        .DIM_BITS  (DIM_BITS),
        .ADDR_BITS (ADDR_BITS)
      ) u_acc (
        .clk       (clk),
        .rst       (rst),
        .adv       (adv),
        .stride    (cell_stride[k]),
        .in_valid  (chain_valid[k]),
        .in_meta   (chain_meta[k]),
        .in_idx    (chain_idx[k]),
        .in_prod   (chain_prod[k]),
        .in_acc    (chain_acc[k]),
        .in_ovf    (chain_ovf[k]),
        .out_valid (chain_valid[k+1]),
        .out_meta  (chain_meta[k+1]),
        .out_idx   (chain_idx[k+1]),
        .out_prod  (chain_prod[k+1]),
        .out_acc   (chain_acc[k+1]),
        .out_ovf   (chain_ovf[k+1])
      );
    end else begin : g_end
      svag_acc_cell #(
        .CELL      (k),
        .MAX_DIMS  (MAX_DIMS),
        .DIM_BITS  (DIM_BITS),
        .ADDR_BITS (ADDR_BITS)
      ) u_acc (
        .clk       (clk),
        .rst       (rst),
        .adv       (adv),
        .stride    (cell_stride[k]),
        .in_valid  (chain_valid[k]),
        .in_meta   (chain_meta[k]),
        .in_idx    (chain_idx[k]),
        .in_prod   (chain_prod[k]),
        .in_acc    (chain_acc[k]),
        .in_ovf    (chain_ovf[k]),
        .out_valid (chain_valid[k+1]),
        .out_meta  (chain_meta[k+1]),
        .out_idx   (),
        .out_prod  (),
        .out_acc   (chain_acc[k+1]),
        .out_ovf   (chain_ovf[k+1])
      );
    end
  end

  assign acc_ext = {{ADDR_W{1'b0}}, chain_acc[MAX_DIMS+1]};

  always_comb begin
    pipe_res.pos    = chain_meta[MAX_DIMS+1].pos;
    pipe_res.last   = chain_meta[MAX_DIMS+1].last;
    pipe_res.addr   = '0;
    pipe_res.status = chain_meta[MAX_DIMS+1].status;
    if (!chain_meta[MAX_DIMS+1].skip) begin
      if (chain_ovf[MAX_DIMS+1]) begin
        pipe_res.status = ST_OVERFLOW;
      end else begin
        pipe_res.addr = acc_ext[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!skid_valid) begin
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tvalid <= chain_valid[MAX_DIMS+1];
      end else if (chain_valid[MAX_DIMS+1]) begin
        skid_valid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b1;
      skid_valid    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      if (!m_axis_tvalid || m_axis_tready) begin
        out_res <= pipe_res;
      end else begin
        skid_res <= pipe_res;
      end
    end else if (m_axis_tready) begin
      out_res <= skid_res;
    end
  end

  assign m_axis_tdata = {out_res.pos, out_res.addr};
  assign m_axis_tlast = out_res.last;
  assign m_axis_tuser = out_res.status;

endmodule
